// ===== sv/fbpa_pkg.sv =====
// Shared types, constants and codes for the fixed block pool allocator.
package fbpa_pkg;

  localparam int MaxBlocks  = 256;
  localparam int IdxW       = 8;
  localparam int CntW       = 9;
  localparam int LinkBytes  = 8;
  localparam int StrideW    = 17;
  localparam int TotalW     = 25;

  typedef enum logic [1:0] {
    CMD_INIT     = 2'd0,
    CMD_ALLOC    = 2'd1,
    CMD_FREE     = 2'd2,
    CMD_SHUTDOWN = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_INVALID   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_OWNED = 3'd4,
    ST_NOT_ALLOC = 3'd5
  } status_t;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_ALIGN = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_check;   // register the init checks
    logic init_latch;  // latch the pool and reset stats
    logic link_write;  // write one link during the init sweep
    logic do_alloc;    // pop the head
    logic div_start;   // load divider with the free offset
    logic div_step;    // one divider iteration
    logic do_free;     // push the divided index
    logic do_clear;    // shutdown
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    ready;       // pool initialized
    logic    cfg_ok;      // registered init checks passed
    logic    sweep_last;  // sweep index at last block
    logic    can_alloc;   // a free block exists
    logic    in_range;    // free address inside the pool
    logic    div_done;    // divider finished
    logic    rem_zero;    // remainder is zero
    logic    is_alloc;    // map bit of the divided index
  } dp_stat_t;

endpackage

// ===== sv/fbpa_ctrl.sv =====
// Controller state machine of the fixed block pool allocator.
module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          cmd,
  input  logic                out_take,
  output logic                out_load,
  output fbpa_pkg::status_t   out_status,
  output logic                out_hit,
  output fbpa_pkg::dp_cmd_t   dpc,
  input  fbpa_pkg::dp_stat_t  dps
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT_CHK, S_SWEEP, S_DIV, S_FREE_CHK, S_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_out_r, busy_out_nxt;

  // Accept an item only when idle and the output register is free.
  assign in_tready = (state_r == S_IDLE) && !busy_out_r;

  always_comb begin
    state_nxt    = state_r;
    busy_out_nxt = busy_out_r && !out_take;
    dpc          = '0;
    out_load     = 1'b0;
    out_status   = fbpa_pkg::ST_OK;
    out_hit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          unique case (fbpa_pkg::cmd_t'(cmd))
            fbpa_pkg::CMD_INIT: begin
              if (dps.ready) begin
                out_load = 1'b1; out_status = fbpa_pkg::ST_ALREADY;
              end else begin
                dpc.cfg_check = 1'b1; state_nxt = S_INIT_CHK;
              end
            end
            fbpa_pkg::CMD_ALLOC: begin
              out_load = 1'b1;
              if (dps.can_alloc) begin
                dpc.do_alloc = 1'b1; out_hit = 1'b1;
              end else begin
                out_status = fbpa_pkg::ST_EMPTY;
              end
            end
            fbpa_pkg::CMD_FREE: begin
              if (!dps.in_range) begin
                out_load = 1'b1; out_status = fbpa_pkg::ST_NOT_OWNED;
              end else begin
                dpc.div_start = 1'b1; state_nxt = S_DIV;
              end
            end
            fbpa_pkg::CMD_SHUTDOWN: begin
              dpc.do_clear = 1'b1; out_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_INIT_CHK: begin
        if (dps.cfg_ok) begin
          dpc.init_latch = 1'b1; state_nxt = S_SWEEP;
        end else begin
          out_load = 1'b1; out_status = fbpa_pkg::ST_INVALID; state_nxt = S_WAIT;
        end
      end
      S_SWEEP: begin
        dpc.link_write = 1'b1;
        if (dps.sweep_last) begin
          out_load = 1'b1; state_nxt = S_WAIT;
        end
      end
      S_DIV: begin
        if (dps.div_done) state_nxt = S_FREE_CHK;
        else dpc.div_step = 1'b1;
      end
      S_FREE_CHK: begin
        out_load = 1'b1; state_nxt = S_WAIT;
        if (!dps.rem_zero) out_status = fbpa_pkg::ST_NOT_OWNED;
        else if (!dps.is_alloc) out_status = fbpa_pkg::ST_NOT_ALLOC;
        else begin
          dpc.do_free = 1'b1; out_hit = 1'b1;
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (out_load) busy_out_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      busy_out_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      busy_out_r <= busy_out_nxt;
    end
  end

endmodule

// ===== sv/fbpa_dp.sv =====
// Datapath of the fixed block pool allocator: registers, link memory, divider.
module fbpa_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_val,
  input  logic [31:0]         in_addr,
  input  fbpa_pkg::dp_cmd_t   dpc,
  output fbpa_pkg::dp_stat_t  dps,
  output logic [31:0]         res_addr,
  output logic [7:0]          res_index,
  output logic [8:0]          res_count,
  output logic [8:0]          res_peak,
  output logic [16:0]         res_stride,
  output logic [24:0]         res_total
);

  localparam int IW = fbpa_pkg::IdxW;
  localparam int CW = fbpa_pkg::CntW;
  localparam int SW = fbpa_pkg::StrideW;
  localparam int TW = fbpa_pkg::TotalW;

  // Configuration registers.
  logic [31:0] base_r;
  logic [15:0] size_r;
  logic [3:0]  align_r;
  logic [CW-1:0] count_r;

  // Pool state.
  logic [IW-1:0] link_mem [fbpa_pkg::MaxBlocks];
  logic          map_mem [fbpa_pkg::MaxBlocks];
  logic          map_rd_r;
  logic [IW-1:0] head_r;
  logic          empty_r, ready_r;
  logic [CW-1:0] used_r, peak_r, blocks_r;
  logic [SW-1:0] stride_r;
  logic [TW-1:0] bytes_r;
  logic [31:0]   pbase_r;

  // Init checks, registered once.
  logic          ok_r;
  logic [SW-1:0] cs_stride_r;
  logic [TW-1:0] cs_total_r;
  logic [IW-1:0] sweep_r;

  // Divider: 25-bit offset by 17-bit stride, one quotient bit a cycle.
  logic [TW-1:0] dq_r;
  logic [SW:0]   drem_r;
  logic [4:0]    dcnt_r;
  logic [SW:0]   dtrial;

  // Head link read, registered.
  logic [IW-1:0] head_link_r;

  // Combinational stride calculation.
  logic [16:0] min_size, align_v, mask_v;
  logic [17:0] stride_w;
  logic [33:0] total_w;
  logic [32:0] end_w;
  logic        cfg_ok_c;
  logic [32:0] off_w;

  always_comb begin
    min_size = (size_r < 16'(fbpa_pkg::LinkBytes)) ? 17'(fbpa_pkg::LinkBytes)
                                                   : {1'b0, size_r};
    align_v  = (align_r > 4'd12) ? 17'd1 : (17'd1 << align_r);
    if (align_v < 17'(fbpa_pkg::LinkBytes)) align_v = 17'(fbpa_pkg::LinkBytes);
    mask_v   = align_v - 17'd1;
    stride_w = (18'(min_size) + 18'(mask_v)) & ~18'(mask_v);
    total_w  = 34'(stride_w) * 34'(count_r);
    end_w    = 33'(base_r) + 33'(total_w[24:0]);
    cfg_ok_c = (size_r != 16'd0) && (count_r != '0) &&
               (count_r <= CW'(fbpa_pkg::MaxBlocks)) && (align_r <= 4'd12) &&
               (stride_w <= 18'h1FFFF) && (total_w <= 34'h1FFFFFF) &&
               (end_w <= 33'h100000000);
    off_w    = {1'b0, in_addr} - {1'b0, pbase_r};
  end

  assign dtrial = {drem_r[SW-1:0], dq_r[TW-1]} - {1'b0, stride_r};

  assign dps.ready      = ready_r;
  assign dps.cfg_ok     = ok_r;
  assign dps.sweep_last = ({1'b0, sweep_r} == blocks_r - CW'(1));
  assign dps.can_alloc  = ready_r && !empty_r && (used_r < blocks_r);
  assign dps.in_range   = ready_r && (stride_r != '0) && !off_w[32] &&
                          (off_w[31:0] < 32'(bytes_r));
  assign dps.div_done   = (dcnt_r == 5'(TW));
  assign dps.rem_zero   = (drem_r == '0);
  assign dps.is_alloc   = map_rd_r;

  // Config writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; size_r <= 16'd64; align_r <= 4'd3; count_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fbpa_pkg::REG_BASE:  base_r  <= cfg_val;
        fbpa_pkg::REG_SIZE:  size_r  <= cfg_val[15:0];
        fbpa_pkg::REG_ALIGN: align_r <= cfg_val[3:0];
        fbpa_pkg::REG_COUNT: count_r <= cfg_val[CW-1:0];
        default: ;
      endcase
    end
  end

  // Link memory: one write, one read a cycle.
  always_ff @(posedge clk) begin
    if (dpc.link_write) link_mem[sweep_r] <= sweep_r + IW'(1);
    else if (dpc.do_free) link_mem[dq_r[IW-1:0]] <= head_r;
    head_link_r <= link_mem[head_r];
  end

  // Allocated map: cleared entry by entry in the init sweep, so only blocks
  // of the current pool are ever read. One write and one registered read.
  always_ff @(posedge clk) begin
    if (dpc.link_write) map_mem[sweep_r] <= 1'b0;
    else if (dpc.do_alloc) map_mem[head_r] <= 1'b1;
    else if (dpc.do_free) map_mem[dq_r[IW-1:0]] <= 1'b0;
    map_rd_r <= map_mem[dq_r[IW-1:0]];
  end

  // Checks, divider and sweep counter.
  always_ff @(posedge clk) begin
    if (dpc.cfg_check) begin
      ok_r <= cfg_ok_c; cs_stride_r <= stride_w[SW-1:0]; cs_total_r <= total_w[TW-1:0];
    end
    if (dpc.div_start) begin
      dq_r <= off_w[TW-1:0]; drem_r <= '0; dcnt_r <= '0;
    end else if (dpc.div_step) begin
      dcnt_r <= dcnt_r + 5'd1;
      if (!dtrial[SW]) begin
        drem_r <= dtrial; dq_r <= {dq_r[TW-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[SW-1:0], dq_r[TW-1]}; dq_r <= {dq_r[TW-2:0], 1'b0};
      end
    end
    if (dpc.init_latch) sweep_r <= '0;
    else if (dpc.link_write) sweep_r <= sweep_r + IW'(1);
  end

  // Pool control state.
  always_ff @(posedge clk) begin
    if (!rst_n || dpc.do_clear) begin
      head_r <= '0; empty_r <= 1'b1; ready_r <= 1'b0;
      used_r <= '0; peak_r <= '0; blocks_r <= '0; stride_r <= '0;
      bytes_r <= '0; pbase_r <= '0;
    end else if (dpc.init_latch) begin
      head_r <= '0; empty_r <= 1'b0; ready_r <= 1'b1;
      used_r <= '0; peak_r <= '0; blocks_r <= count_r; stride_r <= cs_stride_r;
      bytes_r <= cs_total_r; pbase_r <= base_r;
    end else if (dpc.do_alloc) begin
      used_r <= used_r + CW'(1);
      if (used_r + CW'(1) > peak_r) peak_r <= used_r + CW'(1);
      if (used_r + CW'(1) >= blocks_r) empty_r <= 1'b1;
      else head_r <= head_link_r;
    end else if (dpc.do_free) begin
      head_r <= dq_r[IW-1:0];
      empty_r <= 1'b0;
      if (used_r != '0) used_r <= used_r - CW'(1);
    end
  end

  // Result fields (the top samples address and index when loading the output register; stats pass straight through).
  logic [31:0] prod_addr;
  assign prod_addr  = pbase_r + 32'(head_r) * 32'(stride_r);
  assign res_addr   = prod_addr;
  assign res_index  = dpc.do_free ? dq_r[IW-1:0] : head_r;
  assign res_count  = used_r;
  assign res_peak   = peak_r;
  assign res_stride = stride_r;
  assign res_total  = bytes_r;

endmodule

// ===== sv/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator top level: stream ports, output register, checks.
// Usage: one item at a time. Allocate, shutdown, an init of a live pool and
// a free outside the pool answer straight from idle; an init with a bad
// configuration answers from the check state; any other free runs the 25-step
// shift-subtract divider that turns the offset into a block index; a good
// init runs the link memory sweep that writes one free-list link a cycle.
// Results wait in an output register.
module fixed_block_pool_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] command, [33:2] address, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [103:0] out_tdata, // status[2:0], block_address[34:3],
                                  // block_index[42:35], allocated_count[51:43],
                                  // high_water_mark[60:52], stride_bytes[77:61],
                                  // total_bytes[102:78], rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  fbpa_pkg::dp_cmd_t  dpc;
  fbpa_pkg::dp_stat_t dps;
  fbpa_pkg::status_t  st;
  logic        load, hit, take;
  logic [31:0] r_addr;
  logic [7:0]  r_idx;
  logic [8:0]  r_cnt, r_peak;
  logic [16:0] r_str;
  logic [24:0] r_tot;
  logic        out_valid_r;
  logic [2:0]  st_r;
  logic [31:0] addr_r;
  logic [7:0]  idx_r;

  assign cfg_ready  = 1'b1;
  assign take       = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;

  fbpa_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .cmd(in_tdata[1:0]),
    .out_take(take), .out_load(load), .out_status(st), .out_hit(hit), .dpc, .dps
  );

  fbpa_dp u_dp (
    .clk, .rst_n, .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .in_addr(in_tdata[33:2]), .dpc, .dps, .res_addr(r_addr), .res_index(r_idx),
    .res_count(r_cnt), .res_peak(r_peak), .res_stride(r_str), .res_total(r_tot)
  );

  // Output register for status, address and index; stats come straight from the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
    if (load) begin
      st_r    <= st;
      addr_r  <= (hit && dpc.do_alloc) ? r_addr : 32'd0;
      idx_r   <= hit ? r_idx : 8'd0;
    end
  end

  assign out_tdata = {1'b0, r_tot, r_str, r_peak, r_cnt, idx_r, addr_r, st_r};

  // The output register and a new item are never both busy.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> !in_tready)
    else $error("item accepted while result pending");
  // A result is loaded only when none is pending.
  assert property (@(posedge clk) disable iff (!rst_n) load |-> !out_valid_r)
    else $error("result overwritten");
  // Allocate and free are never commanded together.
  assert property (@(posedge clk) disable iff (!rst_n) !(dpc.do_alloc && dpc.do_free))
    else $error("alloc and free together");
  // Shutdown leaves the pool uninitialized.
  assert property (@(posedge clk) disable iff (!rst_n) dpc.do_clear |=> !dps.ready)
    else $error("shutdown kept pool");

endmodule

// ===== sim/tb_fixed_block_pool_allocator.sv =====
// Self-checking testbench for the fixed block pool allocator with a built-in pool predictor.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;   // [1:0] command, [33:2] address, rest zero
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // status, block_address, block_index, allocated_count,
                            // high_water_mark, stride_bytes, total_bytes, rest zero
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  // Listed from the highest bits down, so status lands in the lowest bits.
  typedef struct packed {
    logic [24:0] total_bytes;
    logic [16:0] stride_bytes;
    logic [8:0]  high_water_mark;
    logic [8:0]  allocated_count;
    logic [7:0]  block_index;
    logic [31:0] block_address;
    logic [2:0]  status;
  } pool_result_t;

  // Register copies held by the predictor.
  logic [31:0] reg_base;
  logic [15:0] reg_size;
  logic [3:0]  reg_align;
  logic [8:0]  reg_count;

  // Predicted pool state.
  logic [7:0]  link_mem [fbpa_pkg::MaxBlocks];
  logic        owned_map [fbpa_pkg::MaxBlocks];
  logic [7:0]  head_idx;
  logic        free_empty;
  logic [8:0]  used_blocks;
  logic [8:0]  peak_blocks;
  logic        pool_ready;
  logic [16:0] pool_stride;
  logic [24:0] pool_bytes;
  logic [31:0] pool_base;
  logic [8:0]  pool_blocks;

  pool_result_t expected_results[$];
  logic [31:0]  live_addrs[$];
  int           error_count;
  int           sender_idle_en;
  int           receiver_idle_en;
  int           receiver_hold;

  fixed_block_pool_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous fixed limit for the whole run.
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void clear_pool_state();
    for (int i = 0; i < fbpa_pkg::MaxBlocks; i++) begin
      owned_map[i] = 1'b0;
    end
    head_idx    = '0;
    free_empty  = 1'b1;
    used_blocks = '0;
    peak_blocks = '0;
    pool_ready  = 1'b0;
    pool_stride = '0;
    pool_bytes  = '0;
    pool_base   = '0;
    pool_blocks = '0;
  endfunction

  // Init: returns the status and latches the pool on success.
  function automatic logic [2:0] predict_init();
    longint unsigned min_sz;
    longint unsigned algn;
    longint unsigned strd;
    longint unsigned tot;
    if (pool_ready) return fbpa_pkg::ST_ALREADY;
    if (reg_size == 0 || reg_count == 0 || reg_count > fbpa_pkg::MaxBlocks)
      return fbpa_pkg::ST_INVALID;
    if (reg_align > 12) return fbpa_pkg::ST_INVALID;
    min_sz = (reg_size < fbpa_pkg::LinkBytes) ? fbpa_pkg::LinkBytes : reg_size;
    algn   = 64'd1 << reg_align;
    if (algn < fbpa_pkg::LinkBytes) algn = fbpa_pkg::LinkBytes;
    strd = ((min_sz + algn - 1) / algn) * algn;
    tot  = strd * reg_count;
    if (strd > 64'h1FFFF || tot > 64'h1FFFFFF) return fbpa_pkg::ST_INVALID;
    if (longint'(reg_base) + tot > 64'h1_0000_0000) return fbpa_pkg::ST_INVALID;
    pool_base   = reg_base;
    pool_stride = strd[16:0];
    pool_bytes  = tot[24:0];
    pool_blocks = reg_count;
    used_blocks = '0;
    peak_blocks = '0;
    for (int i = 0; i < fbpa_pkg::MaxBlocks; i++) begin
      owned_map[i] = 1'b0;
      if (i < reg_count) link_mem[i] = 8'(i + 1);
    end
    head_idx   = '0;
    free_empty = 1'b0;
    pool_ready = 1'b1;
    return fbpa_pkg::ST_OK;
  endfunction

  // Works out the result of one command and advances the predicted pool.
  function automatic pool_result_t predict_pool(fbpa_pkg::cmd_t cmd, logic [31:0] addr);
    pool_result_t    r;
    longint unsigned off;
    logic [7:0]      idx;
    r = '0;
    r.status = fbpa_pkg::ST_OK;
    case (cmd)
      fbpa_pkg::CMD_INIT: begin
        r.status = predict_init();
      end
      fbpa_pkg::CMD_ALLOC: begin
        if (!pool_ready || free_empty || used_blocks >= pool_blocks) begin
          r.status = fbpa_pkg::ST_EMPTY;
        end else begin
          idx = head_idx;
          owned_map[idx] = 1'b1;
          used_blocks++;
          if (used_blocks > peak_blocks) peak_blocks = used_blocks;
          if (used_blocks >= pool_blocks) free_empty = 1'b1;
          else head_idx = link_mem[idx];
          r.block_index   = idx;
          r.block_address = pool_base + idx * pool_stride;
        end
      end
      fbpa_pkg::CMD_FREE: begin
        off = longint'(addr) - longint'(pool_base);
        if (!pool_ready || pool_stride == 0 || addr < pool_base ||
            off >= pool_bytes || (off % pool_stride) != 0) begin
          r.status = fbpa_pkg::ST_NOT_OWNED;
        end else begin
          idx = 8'(off / pool_stride);
          if (!owned_map[idx]) begin
            r.status = fbpa_pkg::ST_NOT_ALLOC;
          end else begin
            link_mem[idx]  = head_idx;
            head_idx       = idx;
            free_empty     = 1'b0;
            owned_map[idx] = 1'b0;
            if (used_blocks > 0) used_blocks--;
            r.block_index = idx;
          end
        end
      end
      default: begin
        clear_pool_state();
      end
    endcase
    r.allocated_count = used_blocks;
    r.high_water_mark = peak_blocks;
    r.stride_bytes    = pool_stride;
    r.total_bytes     = pool_bytes;
    return r;
  endfunction

  // Sends one command item, predicts its result and tracks live blocks.
  // Valid stays high after an accept so that items can follow back to back.
  task automatic send_command(fbpa_pkg::cmd_t cmd, logic [31:0] addr);
    pool_result_t r;
    int           gap;
    if (sender_idle_en != 0 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, addr, cmd};
    do @(posedge clk); while (!in_tready);
    r = predict_pool(cmd, addr);
    expected_results.push_back(r);
    if (cmd == fbpa_pkg::CMD_ALLOC && r.status == fbpa_pkg::ST_OK)
      live_addrs.push_back(r.block_address);
    if (cmd == fbpa_pkg::CMD_INIT && r.status == fbpa_pkg::ST_OK) live_addrs.delete();
    if (cmd == fbpa_pkg::CMD_SHUTDOWN) live_addrs.delete();
    if (cmd == fbpa_pkg::CMD_FREE && r.status == fbpa_pkg::ST_OK) begin
      foreach (live_addrs[i]) begin
        if (live_addrs[i] == addr) begin
          live_addrs.delete(i);
          break;
        end
      end
    end
  endtask

  // Waits until every expected result is back, then lets the block settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Drives one register write; the caller drops valid after its last write.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fbpa_pkg::REG_BASE:  reg_base  = value;
      fbpa_pkg::REG_SIZE:  reg_size  = value[15:0];
      fbpa_pkg::REG_ALIGN: reg_align = value[3:0];
      default:             reg_count = value[8:0];
    endcase
  endtask

  task automatic set_pool(logic [31:0] base, logic [15:0] size, logic [3:0] algn,
                          logic [8:0] count);
    drain_results();
    write_register(fbpa_pkg::REG_BASE, base);
    write_register(fbpa_pkg::REG_SIZE, {16'b0, size});
    write_register(fbpa_pkg::REG_ALIGN, {28'b0, algn});
    write_register(fbpa_pkg::REG_COUNT, {23'b0, count});
    cfg_valid <= 1'b0;
  endtask

  // Picks a free target: mostly live blocks, sometimes stray addresses.
  function automatic logic [31:0] pick_free_addr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && live_addrs.size() != 0)
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    if (sel < 8 && pool_stride != 0)
      return pool_base + $urandom_range(0, pool_blocks - 1) * pool_stride;
    if (sel == 8) return pool_base + $urandom_range(0, 3 * pool_stride + 4);
    return $urandom();
  endfunction

  // Directed: bad configurations, extremes of every field, each status code.
  task automatic test_directed();
    send_command(fbpa_pkg::CMD_ALLOC, 32'h0);
    send_command(fbpa_pkg::CMD_FREE, 32'h0);
    send_command(fbpa_pkg::CMD_SHUTDOWN, 32'hFFFF_FFFF);
    set_pool(32'h0, 16'h0, 4'd3, 9'd4);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    set_pool(32'h0, 16'd1, 4'd13, 9'd4);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    set_pool(32'h0, 16'd1, 4'd0, 9'd0);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    set_pool(32'h0, 16'd1, 4'd0, 9'd257);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    set_pool(32'h0, 16'hFFFF, 4'd12, 9'd256);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    set_pool(32'hFFFF_FFF0, 16'd8, 4'd0, 9'd2);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    set_pool(32'hFFFF_FFF0, 16'd8, 4'd0, 9'd1);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    send_command(fbpa_pkg::CMD_ALLOC, 32'h0);
    send_command(fbpa_pkg::CMD_ALLOC, 32'h0);
    send_command(fbpa_pkg::CMD_FREE, 32'hFFFF_FFF0);
    send_command(fbpa_pkg::CMD_FREE, 32'hFFFF_FFF0);
    send_command(fbpa_pkg::CMD_FREE, 32'hFFFF_FFF4);
    send_command(fbpa_pkg::CMD_FREE, 32'h0);
    send_command(fbpa_pkg::CMD_SHUTDOWN, 32'h0);
    set_pool(32'h0, 16'd1, 4'd12, 9'd3);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    send_command(fbpa_pkg::CMD_ALLOC, 32'h0);
    send_command(fbpa_pkg::CMD_FREE, 32'h1000);
    send_command(fbpa_pkg::CMD_FREE, 32'h0);
    send_command(fbpa_pkg::CMD_SHUTDOWN, 32'h0);
  endtask

  // Random sessions: mostly alloc/free traffic over a fresh pool each time.
  task automatic test_random_sessions(int total);
    int          sent;
    int          len;
    int          pick;
    logic [3:0]  algn;
    logic [15:0] size;
    logic [8:0]  count;
    sent = 0;
    while (sent < total) begin
      pick  = $urandom_range(0, 9);
      count = (pick == 0) ? 9'd256 : 9'($urandom_range(1, 24));
      algn  = (pick == 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 12));
      size  = (pick == 2) ? 16'($urandom()) : 16'($urandom_range(0, 200));
      set_pool((pick == 3) ? $urandom() : 32'($urandom_range(0, 65535)) << 4,
               size, algn, (pick == 4) ? 9'($urandom()) : count);
      send_command(fbpa_pkg::CMD_INIT, $urandom());
      sent++;
      len = $urandom_range(20, 90);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) send_command(fbpa_pkg::CMD_ALLOC, $urandom());
        else if (pick < 95) send_command(fbpa_pkg::CMD_FREE, pick_free_addr());
        else if (pick < 98) send_command(fbpa_pkg::CMD_INIT, $urandom());
        else send_command(fbpa_pkg::CMD_SHUTDOWN, $urandom());
      end
      sent += len;
      send_command(fbpa_pkg::CMD_SHUTDOWN, $urandom());
      sent++;
    end
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    set_pool(32'h1000, 16'd16, 4'd4, 9'd8);
    send_command(fbpa_pkg::CMD_INIT, 32'h0);
    receiver_hold = 400;
    for (int i = 0; i < 20; i++) begin
      send_command(fbpa_pkg::cmd_t'((i % 2 == 0) ? fbpa_pkg::CMD_ALLOC : fbpa_pkg::CMD_FREE),
                   pick_free_addr());
    end
    send_command(fbpa_pkg::CMD_SHUTDOWN, 32'h0);
  endtask

  // Final stretch with no idling on either side.
  task automatic test_full_rate();
    sender_idle_en   = 0;
    receiver_idle_en = 0;
    test_random_sessions(150);
  endtask

  // Receiver: random stalls, long hold when asked, and result checking.
  initial begin
    pool_result_t got;
    pool_result_t want;
    int           stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (receiver_hold > 0) begin
        out_tready <= 1'b0;
        repeat (receiver_hold) @(posedge clk);
        receiver_hold = 0;
      end else if (receiver_idle_en != 0 && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 6);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata[102:0];
        if (expected_results.size() == 0) begin
          $error("result with no expected item: %h", got);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
          end
          if (got.block_address !== want.block_address) begin
            $error("block_address: expected %h, actual %h",
                   want.block_address, got.block_address);
            error_count++;
          end
          if (got.block_index !== want.block_index) begin
            $error("block_index: expected %0d, actual %0d",
                   want.block_index, got.block_index);
            error_count++;
          end
          if (got.allocated_count !== want.allocated_count) begin
            $error("allocated_count: expected %0d, actual %0d",
                   want.allocated_count, got.allocated_count);
            error_count++;
          end
          if (got.high_water_mark !== want.high_water_mark) begin
            $error("high_water_mark: expected %0d, actual %0d",
                   want.high_water_mark, got.high_water_mark);
            error_count++;
          end
          if (got.stride_bytes !== want.stride_bytes) begin
            $error("stride_bytes: expected %0d, actual %0d",
                   want.stride_bytes, got.stride_bytes);
            error_count++;
          end
          if (got.total_bytes !== want.total_bytes) begin
            $error("total_bytes: expected %0d, actual %0d",
                   want.total_bytes, got.total_bytes);
            error_count++;
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    cfg_valid        = 1'b0;
    cfg_index        = fbpa_pkg::REG_BASE;
    cfg_data         = '0;
    error_count      = 0;
    receiver_hold    = 0;
    sender_idle_en   = 1;
    receiver_idle_en = 1;
    reg_base  = '0;
    reg_size  = 16'd64;
    reg_align = 4'd3;
    reg_count = 9'd256;
    for (int i = 0; i < fbpa_pkg::MaxBlocks; i++) link_mem[i] = '0;
    clear_pool_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    drain_results();
    test_random_sessions(1350);
    test_full_rate();
    drain_results();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fbpa_pkg.sv
sv/fbpa_ctrl.sv
sv/fbpa_dp.sv
sv/fixed_block_pool_allocator.sv
sim/tb_fixed_block_pool_allocator.sv
